// ----- rtl/bbpr_pkg.sv -----
// bbpr_pkg: shared types and constants of the bicubic Bezier patch point rasterizer.
// No dependencies; used by the top, front, queue and back modules and the testbench.
package bbpr_pkg;

  localparam int COORD_BITS_DEF      = 32;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // fields carried with every transaction: type, slot, four raw coords, red, blue
  localparam int IN_COORD_W = 32;
  localparam int PASS_W     = 1 + 4 + 4 * IN_COORD_W + 8 + 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = 3;

  localparam int QUO_BITS    = 16;   // quotient bits of each divider
  localparam int DEPTH_SHIFT = 15;   // depth numerator is (z+w) << 15

  localparam logic [12:0] FRAME_MAX     = 13'd4096;
  localparam logic [12:0] FB_WIDTH_RST  = 13'd640;
  localparam logic [12:0] FB_HEIGHT_RST = 13'd480;
  localparam logic [7:0]  GREEN_LEVEL   = 8'd127;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    CFG_FB_WIDTH  = 1'b0,
    CFG_FB_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// ----- rtl/bicubic_bezier_patch_point_raster_top.sv -----
// Bicubic Bezier patch point rasterizer, top level.
// Throughput: one transaction per cycle while in_stall is low. Path from the accepting edge to
// out_valid: 4 weight stages, 1 queue slot, 6 sum/clip stages, 16 divider stages, output.
// The 16-stage restoring dividers for x, y and depth are the longest part; output stalls hold the path.
// Reset (rst_n, synchronous, low) clears all valid and queue state and sets the
// frame size to 640 x 480; control points stay undefined until loaded.
module bicubic_bezier_patch_point_raster_top #(
  parameter int COORD_BITS      = bbpr_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = bbpr_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [3:0]         in_point_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic signed [31:0] in_coord_w,
  input  logic [16:0]        in_s_param,
  input  logic [16:0]        in_t_param,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_pixel_x,
  output logic [11:0]        out_pixel_y,
  output logic [15:0]        out_depth,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam int QW = bbpr_pkg::PASS_W + 16 * (PARAM_FRAC_BITS + 1);

  logic [12:0] wd_r, ht_r, wd_eff, ht_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r <= bbpr_pkg::FB_WIDTH_RST;
      ht_r <= bbpr_pkg::FB_HEIGHT_RST;
    end else if (cfg_we) begin
      case (bbpr_pkg::cfg_reg_t'(cfg_index))
        bbpr_pkg::CFG_FB_WIDTH:  wd_r <= cfg_data;
        bbpr_pkg::CFG_FB_HEIGHT: ht_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wd_eff = (wd_r > bbpr_pkg::FRAME_MAX) ? bbpr_pkg::FRAME_MAX : wd_r;
  assign ht_eff = (ht_r > bbpr_pkg::FRAME_MAX) ? bbpr_pkg::FRAME_MAX : ht_r;

  logic                push, pop;
  logic [QW-1:0]       push_data, pop_data;
  bbpr_pkg::q_status_t q_status;

  bbpr_front #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_point_index(in_point_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z), .in_coord_w(in_coord_w),
    .in_s_param(in_s_param), .in_t_param(in_t_param),
    .q_full(q_status.full), .push(push), .push_data(push_data)
  );

  bbpr_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data),
    .status(q_status)
  );

  bbpr_back #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_status(q_status), .pop(pop), .pop_data(pop_data),
    .fb_wd(wd_eff), .fb_ht(ht_eff),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_depth(out_depth), .out_red(out_red), .out_blue(out_blue)
  );

  assign out_green = bbpr_pkg::GREEN_LEVEL;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= bbpr_pkg::QCNT_W'(bbpr_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_q_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (q_status.count == bbpr_pkg::QCNT_W'($past(q_status.count) + 1)))
    else $error("queue count did not rise on push");

  a_q_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (q_status.count == bbpr_pkg::QCNT_W'($past(q_status.count) - 1)))
    else $error("queue count did not fall on pop");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/bbpr_front.sv -----
// bbpr_front: accepts transactions and forms the 16 tensor Bernstein weights.
// Depends on bbpr_pkg; feeds bbpr_queue.
module bbpr_front #(
  parameter int PARAM_FRAC_BITS = bbpr_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [3:0]         in_point_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic signed [31:0] in_coord_w,
  input  logic [16:0]        in_s_param,
  input  logic [16:0]        in_t_param,
  input  logic               q_full,
  output logic               push,
  output logic [bbpr_pkg::PASS_W + 16*(PARAM_FRAC_BITS+1) - 1:0] push_data
);

  localparam int F  = PARAM_FRAC_BITS;
  localparam int PW = F + 1;
  localparam int MW = 2 * PW + 2;
  localparam logic [63:0]   ONE64 = 64'd1 << F;
  localparam logic [PW-1:0] ONE_P = PW'(1) << F;
  localparam logic [MW-1:0] HALF  = MW'(1) << (F - 1);

  function automatic logic [PW-1:0] rq(input logic [MW-1:0] a);
    logic [MW-1:0] r;
    r = (a + HALF) >> F;
    return r[PW-1:0];
  endfunction

  logic [3:0] v_r;
  logic       en;
  logic [bbpr_pkg::PASS_W-1:0] pass_r [4];
  logic [bbpr_pkg::PASS_W-1:0] pass_nxt;

  // lane 0 is s, lane 1 is t
  logic [PW-1:0]   s1_r [2], u1_r [2], s1_nxt [2], u1_nxt [2];
  logic [PW+1:0]   s3_r [2], u3_r [2], s3_nxt [2], u3_nxt [2];
  logic [7:0]      col_nxt [2];
  logic [PW-1:0]   s2p_r [2], u2p_r [2], sq_r [2], uq_r [2], sq_nxt [2], uq_nxt [2];
  logic [PW+1:0]   s23_r [2], u23_r [2];
  logic [PW-1:0]   b_r [2][4], b_nxt [2][4];
  logic [PW-1:0]   wt_r [16], wt_nxt [16];

  assign en       = !v_r[3] || !q_full;
  assign in_stall = !en;
  assign push     = v_r[3] && !q_full;

  always_comb begin : st1
    logic [63:0]   sx;
    logic [63:0]   sc;
    logic [PW+7:0] cm;
    for (int l = 0; l < 2; l++) begin
      sx = (l == 0) ? 64'(in_s_param) : 64'(in_t_param);
      sc = (sx > ONE64) ? ONE64 : sx;
      s1_nxt[l] = sc[PW-1:0];
      u1_nxt[l] = ONE_P - sc[PW-1:0];
      s3_nxt[l] = {2'b00, s1_nxt[l]} + {1'b0, s1_nxt[l], 1'b0};
      u3_nxt[l] = {2'b00, u1_nxt[l]} + {1'b0, u1_nxt[l], 1'b0};
      cm = (PW+8)'(sc[PW-1:0]) * (PW+8)'(255);
      col_nxt[l] = cm[F+7:F];
    end
    pass_nxt = {in_req_type, in_point_index, in_coord_x, in_coord_y, in_coord_z,
                in_coord_w, col_nxt[0], col_nxt[1]};
  end

  always_comb begin : st2
    for (int l = 0; l < 2; l++) begin
      sq_nxt[l] = rq(MW'(s1_r[l]) * MW'(s1_r[l]));
      uq_nxt[l] = rq(MW'(u1_r[l]) * MW'(u1_r[l]));
    end
  end

  always_comb begin : st3
    for (int l = 0; l < 2; l++) begin
      b_nxt[l][0] = rq(MW'(uq_r[l]) * MW'(u2p_r[l]));
      b_nxt[l][1] = rq(MW'(s23_r[l]) * MW'(uq_r[l]));
      b_nxt[l][2] = rq(MW'(sq_r[l]) * MW'(u23_r[l]));
      b_nxt[l][3] = rq(MW'(sq_r[l]) * MW'(s2p_r[l]));
    end
  end

  always_comb begin : st4
    for (int i = 0; i < 16; i++) begin
      wt_nxt[i] = rq(MW'(b_r[0][i/4]) * MW'(b_r[1][i%4]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r[0] <= pass_nxt;
      pass_r[1] <= pass_r[0];
      pass_r[2] <= pass_r[1];
      pass_r[3] <= pass_r[2];
      for (int l = 0; l < 2; l++) begin
        s1_r[l]  <= s1_nxt[l];
        u1_r[l]  <= u1_nxt[l];
        s3_r[l]  <= s3_nxt[l];
        u3_r[l]  <= u3_nxt[l];
        s2p_r[l] <= s1_r[l];
        u2p_r[l] <= u1_r[l];
        s23_r[l] <= s3_r[l];
        u23_r[l] <= u3_r[l];
        sq_r[l]  <= sq_nxt[l];
        uq_r[l]  <= uq_nxt[l];
        for (int k = 0; k < 4; k++) begin
          b_r[l][k] <= b_nxt[l][k];
        end
      end
      for (int i = 0; i < 16; i++) begin
        wt_r[i] <= wt_nxt[i];
      end
    end
  end

  always_comb begin
    push_data[bbpr_pkg::PASS_W + 16*PW - 1 -: bbpr_pkg::PASS_W] = pass_r[3];
    for (int i = 0; i < 16; i++) begin
      push_data[i*PW +: PW] = wt_r[i];
    end
  end

endmodule

// ----- rtl/bbpr_queue.sv -----
// bbpr_queue: short register FIFO between the front and back parts.
// Depends on bbpr_pkg for depth and the status struct.
module bbpr_queue #(
  parameter int W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [W-1:0]        push_data,
  input  logic                pop,
  output logic [W-1:0]        pop_data,
  output bbpr_pkg::q_status_t status
);

  localparam int D  = bbpr_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  logic [W-1:0]  mem_r [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [bbpr_pkg::QCNT_W-1:0] cnt_r;

  assign pop_data     = mem_r[rp_r];
  assign status.count = cnt_r;
  assign status.full  = (cnt_r == bbpr_pkg::QCNT_W'(D));
  assign status.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop)  rp_r <= rp_r + AW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + bbpr_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - bbpr_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ----- rtl/bbpr_div.sv -----
// bbpr_div: pipelined restoring divider, one quotient bit per stage.
// No dependencies; quotient must be known to fit QB bits.
module bbpr_div #(
  parameter int NW = 51,
  parameter int DW = 35,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [NW-1:0] rem_r [QB], rem_nxt [QB], rin [QB];
  logic [DW-1:0] den_r [QB], din [QB];
  logic [QB-1:0] q_r [QB], q_nxt [QB], qin [QB];

  always_comb begin
    logic [NW-1:0] sh;
    rin[0] = num;
    din[0] = den;
    qin[0] = '0;
    for (int j = 1; j < QB; j++) begin
      rin[j] = rem_r[j-1];
      din[j] = den_r[j-1];
      qin[j] = q_r[j-1];
    end
    for (int j = 0; j < QB; j++) begin
      sh = NW'(din[j]) << (QB - 1 - j);
      if (rin[j] >= sh) begin
        rem_nxt[j] = rin[j] - sh;
        q_nxt[j]   = qin[j] | (QB'(1) << (QB - 1 - j));
      end else begin
        rem_nxt[j] = rin[j];
        q_nxt[j]   = qin[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QB; j++) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= din[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign quo = q_r[QB-1];

endmodule

// ----- rtl/bbpr_back.sv -----
// bbpr_back: holds the control points, forms the tensor sum, clips, divides, maps.
// Depends on bbpr_pkg and bbpr_div; drains bbpr_queue.
module bbpr_back #(
  parameter int COORD_BITS      = bbpr_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = bbpr_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bbpr_pkg::q_status_t q_status,
  output logic                pop,
  input  logic [bbpr_pkg::PASS_W + 16*(PARAM_FRAC_BITS+1) - 1:0] pop_data,
  input  logic [12:0]         fb_wd,
  input  logic [12:0]         fb_ht,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         out_pixel_x,
  output logic [11:0]         out_pixel_y,
  output logic [15:0]         out_depth,
  output logic [7:0]          out_red,
  output logic [7:0]          out_blue
);

  localparam int F   = PARAM_FRAC_BITS;
  localparam int PW  = F + 1;
  localparam int CB  = COORD_BITS;
  localparam int PRW = CB + PW + 1;
  localparam int ACC = CB + 2;
  localparam int DW  = ACC + 1;
  localparam int QB  = bbpr_pkg::QUO_BITS;
  localparam int NW  = DW + QB;
  localparam int PS  = bbpr_pkg::PASS_W;
  localparam logic signed [PRW-1:0] HALFP = PRW'(1) << (F - 1);

  logic en;
  logic ov_r;

  // unpack queue head
  logic        q_type;
  logic [3:0]  q_idx;
  logic [31:0] q_crd [4];
  logic [15:0] q_col;
  logic [PW-1:0] q_wt [16];

  always_comb begin
    q_type = pop_data[16*PW + PS - 1];
    q_idx  = pop_data[16*PW + PS - 2 -: 4];
    for (int k = 0; k < 4; k++) begin
      q_crd[k] = pop_data[16*PW + 16 + (3-k)*32 +: 32];
    end
    q_col = pop_data[16*PW +: 16];
    for (int i = 0; i < 16; i++) begin
      q_wt[i] = pop_data[i*PW +: PW];
    end
  end

  assign en  = !ov_r || !out_stall;
  assign pop = en && !q_status.empty;

  // control points: x, y, z, w per slot
  logic signed [CB-1:0] cp_r [16][4];

  always_ff @(posedge clk) begin
    logic signed [63:0] ext;
    if (pop && (q_type == bbpr_pkg::REQ_LOAD)) begin
      for (int k = 0; k < 4; k++) begin
        ext = {{32{q_crd[k][31]}}, q_crd[k]};
        cp_r[q_idx][k] <= ext[CB-1:0];
      end
    end
  end

  // pipeline: A products, B..E adder tree, F clip and numerators
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic [15:0] cola_r, colb_r, colc_r, cold_r, cole_r, colf_r;
  logic signed [PRW-1:0] pa_r [16][4], pa_nxt [16][4];
  logic signed [ACC-1:0] sb_r [8][4], sb_nxt [8][4];
  logic signed [ACC-1:0] sc_r [4][4], sc_nxt [4][4];
  logic signed [ACC-1:0] sd_r [2][4], sd_nxt [2][4];
  logic signed [ACC-1:0] se_r [4], se_nxt [4];
  logic [NW-1:0] nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt;
  logic [DW-1:0] d2_r, d1_r, d2_nxt, d1_nxt;
  logic          kf_r, kf_nxt;

  always_comb begin
    logic signed [PRW-1:0] rt;
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 4; k++) begin
        pa_nxt[i][k] = PRW'(cp_r[i][k]) * PRW'($signed({1'b0, q_wt[i]}));
      end
    end
    for (int j = 0; j < 8; j++) begin
      for (int k = 0; k < 4; k++) begin
        rt = (pa_r[2*j][k] + HALFP) >>> F;
        sb_nxt[j][k] = ACC'(rt);
        rt = (pa_r[2*j+1][k] + HALFP) >>> F;
        sb_nxt[j][k] = sb_nxt[j][k] + ACC'(rt);
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) sc_nxt[j][k] = sb_r[2*j][k] + sb_r[2*j+1][k];
      for (int j = 0; j < 2; j++) sd_nxt[j][k] = sc_r[2*j][k] + sc_r[2*j+1][k];
      se_nxt[k] = sd_r[0][k] + sd_r[1][k];
    end
  end

  always_comb begin
    logic signed [ACC:0] we, ce;
    logic [ACC:0]        cw [3];
    we     = (ACC+1)'(se_r[3]);
    kf_nxt = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ce = (ACC+1)'(se_r[k]);
      if (!((ce > -we) && (ce < we))) kf_nxt = 1'b0;
      cw[k] = ce + we;
    end
    nx_nxt = NW'(cw[0]) * NW'(fb_wd);
    ny_nxt = NW'(cw[1]) * NW'(fb_ht);
    nz_nxt = NW'(cw[2]) << bbpr_pkg::DEPTH_SHIFT;
    d2_nxt = DW'(we) << 1;
    d1_nxt = DW'(we);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {va_r, vb_r, vc_r, vd_r, ve_r, vf_r} <= '0;
    end else if (en) begin
      va_r <= pop && (q_type == bbpr_pkg::REQ_EVAL);
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cola_r <= q_col;
      colb_r <= cola_r;
      colc_r <= colb_r;
      cold_r <= colc_r;
      cole_r <= cold_r;
      colf_r <= cole_r;
      pa_r   <= pa_nxt;
      sb_r   <= sb_nxt;
      sc_r   <= sc_nxt;
      sd_r   <= sd_nxt;
      se_r   <= se_nxt;
      nx_r   <= nx_nxt;
      ny_r   <= ny_nxt;
      nz_r   <= nz_nxt;
      d2_r   <= d2_nxt;
      d1_r   <= d1_nxt;
      kf_r   <= kf_nxt;
    end
  end

  // dividers and matching side pipeline
  logic [QB-1:0] qx, qy, qz;

  bbpr_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_x (
    .clk(clk), .en(en), .num(nx_r), .den(d2_r), .quo(qx));
  bbpr_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_y (
    .clk(clk), .en(en), .num(ny_r), .den(d2_r), .quo(qy));
  bbpr_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_z (
    .clk(clk), .en(en), .num(nz_r), .den(d1_r), .quo(qz));

  logic [QB-1:0] mv_r, mk_r;
  logic [15:0]   mc_r [QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
    end else if (en) begin
      mv_r <= {mv_r[QB-2:0], vf_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mk_r    <= {mk_r[QB-2:0], kf_r};
      mc_r[0] <= colf_r;
      for (int j = 1; j < QB; j++) mc_r[j] <= mc_r[j-1];
    end
  end

  // output register
  logic ov_nxt;
  assign ov_nxt = mv_r[QB-1] && mk_r[QB-1] &&
                  (qx < QB'(fb_wd)) && (qy < QB'(fb_ht));

  logic [11:0] px_r, py_r;
  logic [15:0] dz_r;
  logic [7:0]  red_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= qx[11:0];
      py_r   <= qy[11:0];
      dz_r   <= qz[15:0];
      red_r  <= mc_r[QB-1][15:8];
      blue_r <= mc_r[QB-1][7:0];
    end
  end

  assign out_valid   = ov_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_depth   = dz_r;
  assign out_red     = red_r;
  assign out_blue    = blue_r;

endmodule

// ----- sim/bicubic_bezier_patch_point_raster_top_tb.sv -----
// Self-checking testbench for bicubic_bezier_patch_point_raster_top: directed table, then random
// patches in several frame sizes; fragments checked against a bit-exact predictor or typed rows.
// Depends on rtl/bbpr_pkg.sv and the block's RTL only.
module bicubic_bezier_patch_point_raster_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE = 64'd65536;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [15:0] dz;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } frag_t;

  typedef struct {
    bbpr_pkg::req_t kind;
    logic [3:0]  idx;
    logic [31:0] cx, cy, cz, cw;
    logic [16:0] s, t;
    bit          typed;
    frag_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  bbpr_pkg::cfg_reg_t cfg_index = bbpr_pkg::CFG_FB_WIDTH;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [3:0] in_point_index = '0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0, in_coord_w = '0;
  logic [16:0] in_s_param = '0, in_t_param = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] out_pixel_x, out_pixel_y;
  logic [15:0] out_depth;
  logic [7:0] out_red, out_green, out_blue;

  bicubic_bezier_patch_point_raster_top u_dut (
    .clk, .rst_n, .cfg_we, .cfg_index(cfg_index), .cfg_data,
    .in_valid, .in_stall, .in_req_type, .in_point_index,
    .in_coord_x, .in_coord_y, .in_coord_z, .in_coord_w, .in_s_param, .in_t_param,
    .out_valid, .out_stall, .out_pixel_x, .out_pixel_y, .out_depth,
    .out_red, .out_green, .out_blue
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [63:0] patch_pts [16][4];
  logic [12:0] frame_w = bbpr_pkg::FB_WIDTH_RST, frame_h = bbpr_pkg::FB_HEIGHT_RST;
  frag_t frag_q[$];
  int errors = 0;
  bit quiet = 0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] rnd_q(input logic [63:0] a);
    return (a + (ONE >> 1)) >> 16;
  endfunction

  function automatic logic [3:0][63:0] bernstein(input logic [63:0] p);
    logic [63:0] u, p2, u2;
    logic [3:0][63:0] b;
    u = ONE - p;
    p2 = rnd_q(p * p);
    u2 = rnd_q(u * u);
    b[0] = rnd_q(u2 * u);
    b[1] = rnd_q(3 * p * u2);
    b[2] = rnd_q(3 * p2 * u);
    b[3] = rnd_q(p2 * p);
    return b;
  endfunction

  function automatic logic signed [63:0] scale_q(input logic signed [63:0] a,
                                                 input logic [63:0] wt);
    logic [63:0] lo;
    logic signed [63:0] hi;
    lo = a & (ONE - 1);
    hi = (a - $signed(lo)) >>> 16;
    return hi * $signed(wt) + $signed(rnd_q(lo * wt));
  endfunction

  // returns 1 and the fragment when the evaluated point survives clipping
  function automatic bit eval_patch(input logic [16:0] s_in, input logic [16:0] t_in,
                                    output frag_t f);
    logic [63:0] s, t, wt, wd, ht, px, py, dz;
    logic [3:0][63:0] bs, bt;
    logic signed [63:0] acc [4];
    logic signed [63:0] w;
    s = (s_in > ONE) ? ONE : 64'(s_in);
    t = (t_in > ONE) ? ONE : 64'(t_in);
    bs = bernstein(s);
    bt = bernstein(t);
    for (int k = 0; k < 4; k++) acc[k] = 0;
    for (int i = 0; i < 16; i++) begin
      wt = rnd_q(bs[i >> 2] * bt[i & 3]);
      for (int k = 0; k < 4; k++) acc[k] += scale_q(patch_pts[i][k], wt);
    end
    w = acc[3];
    f = '0;
    for (int k = 0; k < 3; k++)
      if (acc[k] <= -w || acc[k] >= w) return 0;
    wd = (frame_w > bbpr_pkg::FRAME_MAX) ? 64'(bbpr_pkg::FRAME_MAX) : 64'(frame_w);
    ht = (frame_h > bbpr_pkg::FRAME_MAX) ? 64'(bbpr_pkg::FRAME_MAX) : 64'(frame_h);
    px = (64'(acc[0] + w) * wd) / (64'(w) * 2);
    py = (64'(acc[1] + w) * ht) / (64'(w) * 2);
    if (px >= wd || py >= ht) return 0;
    dz = (64'(acc[2] + w) << 15) / 64'(w);
    f.px = px[11:0];
    f.py = py[11:0];
    f.dz = dz[15:0];
    f.r = 8'((s * 255) >> 16);
    f.g = bbpr_pkg::GREEN_LEVEL;
    f.b = 8'((t * 255) >> 16);
    return 1;
  endfunction

  function automatic void expect_frag(input frag_t f);
    frag_q.insert(frag_q.size(), f);
  endfunction

  // drive one transaction and hold it until accepted; typed rows override the predictor
  task automatic send(input row_t r);
    frag_t f;
    in_valid <= 1'b1;
    in_req_type <= r.kind;
    in_point_index <= r.idx;
    in_coord_x <= r.cx;
    in_coord_y <= r.cy;
    in_coord_z <= r.cz;
    in_coord_w <= r.cw;
    in_s_param <= r.s;
    in_t_param <= r.t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.kind == bbpr_pkg::REQ_LOAD) begin
      patch_pts[r.idx][0] = $signed(r.cx);
      patch_pts[r.idx][1] = $signed(r.cy);
      patch_pts[r.idx][2] = $signed(r.cz);
      patch_pts[r.idx][3] = $signed(r.cw);
    end else if (r.typed) begin
      expect_frag(r.want);
    end else if (eval_patch(r.s, r.t, f)) begin
      expect_frag(f);
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // each write drops cfg_we again before the next one, keeping cfg_we edges apart
  task automatic write_reg(input bbpr_pkg::cfg_reg_t idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bbpr_pkg::CFG_FB_WIDTH) frame_w = val;
    else frame_h = val;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (frag_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic row_t load_row(input logic [3:0] idx, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z,
                                    input logic [31:0] w);
    row_t r;
    r.kind = bbpr_pkg::REQ_LOAD; r.idx = idx;
    r.cx = x; r.cy = y; r.cz = z; r.cw = w;
    r.s = 17'($urandom); r.t = 17'($urandom);
    r.typed = 0; r.want = '0;
    return r;
  endfunction

  function automatic row_t eval_row(input logic [16:0] s, input logic [16:0] t);
    row_t r;
    r.kind = bbpr_pkg::REQ_EVAL; r.idx = 4'($urandom);
    r.cx = $urandom; r.cy = $urandom; r.cz = $urandom; r.cw = $urandom;
    r.s = s; r.t = t;
    r.typed = 0; r.want = '0;
    return r;
  endfunction

  function automatic row_t typed_eval(input logic [16:0] s, input logic [16:0] t,
                                      input logic [7:0] r8, input logic [7:0] b8);
    row_t r;
    r = eval_row(s, t);
    r.typed = 1;
    r.want = '{px: 12'd320, py: 12'd240, dz: 16'd32768, r: r8,
               g: bbpr_pkg::GREEN_LEVEL, b: b8};
    return r;
  endfunction

  // mostly well-formed point inside the clip volume; w occasionally negative
  function automatic row_t sane_point(input logic [3:0] idx);
    int w, span;
    w = $urandom_range(32768, 131072);
    span = w * 9 / 10;
    if ($urandom_range(0, 19) == 0) w = -w;
    return load_row(idx, $urandom_range(0, 2 * span) - span,
                    $urandom_range(0, 2 * span) - span,
                    $urandom_range(0, 2 * span) - span, w);
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'(ONE);
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    frag_t got, exp_f;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bicubic_bezier_patch_point_raster_top regression: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{out_pixel_x, out_pixel_y, out_depth, out_red, out_green, out_blue};
        if (frag_q.size() == 0) begin
          $display("%0t: unexpected fragment expected none actual %p", $time, got);
          errors++;
        end else begin
          exp_f = frag_q.pop_front();
          if (got !== exp_f) begin
            $display("%0t: fragment mismatch expected %p actual %p", $time, exp_f, got);
            errors++;
          end
        end
      end
    end
  end

  row_t directed[$];
  logic [12:0] phase_w[5] = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd0};
  logic [12:0] phase_h[5] = '{13'd1, 13'd4096, 13'd8191, 13'd300, 13'd0};

  function automatic void add_row(input row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flat patch at the origin: always pixel center of a 640x480 frame, mid depth
    for (int i = 0; i < 16; i++) add_row(load_row(4'(i), 0, 0, 0, 32'd65536));
    add_row(typed_eval(17'd0, 17'd0, 8'd0, 8'd0));
    add_row(typed_eval(17'd65536, 17'd65536, 8'd255, 8'd255));
    add_row(typed_eval(17'd131071, 17'd0, 8'd255, 8'd0));
    add_row(typed_eval(17'd0, 17'h1FFFF, 8'd0, 8'd255));
    add_row(typed_eval(17'd32768, 17'd32768, 8'd127, 8'd127));
    add_row(load_row(4'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000));
    add_row(eval_row(17'd0, 17'd0));
    add_row(eval_row(17'd16384, 17'd49152));
    add_row(load_row(4'd5, 30000, -20000, 10000, 70000));
    add_row(eval_row(17'd21845, 17'd43690));
    foreach (directed[i]) send(directed[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        phase_w[4] = 13'($urandom_range(1, 8191));
        phase_h[4] = 13'($urandom_range(1, 8191));
        quiet = 1;
      end
      write_reg(bbpr_pkg::CFG_FB_WIDTH, phase_w[ph]);
      write_reg(bbpr_pkg::CFG_FB_HEIGHT, phase_h[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 60 == 0)
          for (int i = 0; i < 16; i++) send(sane_point(4'(i)));
        if (ph == 1 && n == 100) hold_left = 80;
        case ($urandom_range(0, 19))
          0, 1: send(sane_point(4'($urandom)));
          2: send(load_row(4'($urandom), $urandom, $urandom, $urandom, $urandom));
          default: send(eval_row(rand_param(), rand_param()));
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("bicubic_bezier_patch_point_raster_top regression: pass");
    end else begin
      $display("bicubic_bezier_patch_point_raster_top regression: fail");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/bbpr_pkg.sv
rtl/bbpr_front.sv
rtl/bbpr_queue.sv
rtl/bbpr_div.sv
rtl/bbpr_back.sv
rtl/bicubic_bezier_patch_point_raster_top.sv
sim/bicubic_bezier_patch_point_raster_top_tb.sv
